>>> rtl/core/adcod_pkg.sv
// ----------------------------------------------------------------------------
// adcod_pkg
// Shared widths, mode codes and the per-item step record of the converter
// sample decimator.
// ----------------------------------------------------------------------------
package adcod_pkg;

  // field and state widths
  localparam int SAMPLE_W   = 10;
  localparam int RESULT_W   = 16;
  localparam int MODE_W     = 5;
  localparam int ACC_W      = 22;
  localparam int CNT_W      = 13;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 16;
  localparam int OVS_SHIFT_W = 3;

  // default converter resolution
  localparam int SAMPLE_BITS_DEF = 10;

  // resolution mode codes
  localparam logic [MODE_W-1:0] MODE_DIRECT_MIN = 5'd8;
  localparam logic [MODE_W-1:0] MODE_DIRECT_MAX = 5'd10;
  localparam logic [MODE_W-1:0] MODE_OVS_MIN    = 5'd11;
  localparam logic [MODE_W-1:0] MODE_OVS_MAX    = 5'd16;
  localparam logic [MODE_W-1:0] MODE_RESET      = 5'd10;
  localparam logic [MODE_W-1:0] MODE_OVS_BASE   = 5'd10;

  // full oversampling count for the deepest mode (4^6)
  localparam logic [CNT_W-1:0] CNT_MAX = 13'd4096;

  // outcome of one item: result and next accumulator state
  typedef struct packed {
    logic                emit;
    logic                upd;
    logic [RESULT_W-1:0] result;
    logic [ACC_W-1:0]    acc;
    logic [CNT_W-1:0]    cnt;
  } adcod_step_t;

endpackage

>>> rtl/core/adcod_step.sv
// ----------------------------------------------------------------------------
// adcod_step
// Combinational work for one sample: direct shift or oversampling
// accumulate, emit on the trigger sample and clear.
// ----------------------------------------------------------------------------
module adcod_step
  import adcod_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [MODE_W-1:0]   mode,
  input  logic [ACC_W-1:0]    acc,
  input  logic [CNT_W-1:0]    cnt,
  output adcod_step_t         step
);

  localparam logic [RESULT_W-1:0] SMASK = RESULT_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [MODE_W-1:0]   SB    = MODE_W'(SAMPLE_BITS);

  logic [RESULT_W-1:0]    s_ext;
  logic [RESULT_W-1:0]    direct_val;
  logic [OVS_SHIFT_W-1:0] n;
  logic [CNT_W-1:0]       target;
  logic                   is_direct;
  logic                   is_ovs;

  // sample limited to the converter width
  assign s_ext = RESULT_W'(sample) & SMASK;

  assign is_direct = (mode >= MODE_DIRECT_MIN) && (mode <= MODE_DIRECT_MAX);
  assign is_ovs    = (mode >= MODE_OVS_MIN) && (mode <= MODE_OVS_MAX);

  // direct modes: align sample to the requested width
  always_comb begin
    if (mode <= SB) begin
      direct_val = s_ext >> (SB - mode);
    end else begin
      direct_val = s_ext << (mode - SB);
    end
  end

  // oversampling depth and sample target 4^n
  assign n      = OVS_SHIFT_W'(mode - MODE_OVS_BASE);
  assign target = CNT_W'(1) << {n, 1'b0};

  // select outcome
  always_comb begin
    step.emit   = 1'b0;
    step.upd    = 1'b0;
    step.result = direct_val;
    step.acc    = acc;
    step.cnt    = cnt;
    if (is_direct) begin
      step.emit = 1'b1;
    end else if (is_ovs) begin
      step.upd = 1'b1;
      if (cnt < target) begin
        step.acc = acc + ACC_W'(s_ext);
        step.cnt = cnt + CNT_W'(1);
      end else begin
        // trigger sample is dropped, sum is reported and cleared
        step.emit   = 1'b1;
        step.result = RESULT_W'(acc >> n);
        step.acc    = '0;
        step.cnt    = '0;
      end
    end
  end

endmodule

>>> rtl/core/adc_oversampling_decimator.sv
// ----------------------------------------------------------------------------
// adc_oversampling_decimator
// Converter sample stream to selectable-resolution result stream, with
// direct shift modes and 4^n oversampling with decimation.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata[9:0]   sample
//  out_     out  out_tvalid/out_tready  out_tdata[15:0] result_value
//  cfg_     in   cfg_wr_en              cfg_wr_data[4:0] resolution_bits
//
//  One item per cycle sustained unless a result is stalled; a sample reaches
//  out_tdata through the input register (at acceptance), then the result register.
//  Accumulating samples and mode values 0-7, 17-31 give no result.
//  Reset clears the accumulator, the count and sets the mode to 10.
//  A stalled result holds the result register; the input register then
//  holds one item and in_tready drops once both registers are full.
// ----------------------------------------------------------------------------
module adc_oversampling_decimator
  import adcod_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,    // [9:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,   // [15:0] result_value
  input  logic                   cfg_wr_en,
  input  logic [MODE_W-1:0]      cfg_wr_data
);

  logic                   s1_valid_r;
  logic [SAMPLE_W-1:0]    s1_sample_r;
  logic                   s1_adv;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [RESULT_W-1:0]    out_data_r;
  logic [MODE_W-1:0]      mode_r;
  logic [ACC_W-1:0]       acc_r;
  logic [CNT_W-1:0]       cnt_r;
  adcod_step_t            step;

  // stage advance and input ready
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  // per-item datapath
  adcod_step #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .sample(s1_sample_r),
    .mode  (mode_r),
    .acc   (acc_r),
    .cnt   (cnt_r),
    .step  (step)
  );

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (s1_adv && step.upd) begin
      acc_r <= step.acc;
      cnt_r <= step.cnt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_adv && step.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step.emit) begin
      out_data_r <= step.result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("sample count beyond full oversampling depth");

  a_cnt_zero_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (acc_r == '0))
    else $error("accumulator not clear with empty count");

  a_direct_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (mode_r >= MODE_DIRECT_MIN) && (mode_r <= MODE_DIRECT_MAX))
    |=> out_valid_r)
    else $error("direct mode item produced no result");

  a_direct_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (mode_r >= MODE_DIRECT_MIN) && (mode_r <= MODE_DIRECT_MAX))
    |=> ($stable(acc_r) && $stable(cnt_r)))
    else $error("direct mode item changed accumulator state");

endmodule
